[design/ody_pkg.sv]
// ----------------------------------------------------------------------------
// Odometry package
// Shared widths, fixed-point constants, the arctangent table and the
// sequencer and register index types of the omni drive odometry core.
// ----------------------------------------------------------------------------
package ody_pkg;

    localparam int MUL_AW = 40;
    localparam int MUL_BW = 28;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam int DIV_NW = 48;
    localparam int DIV_DW = 20;

    localparam int COR_W = 32;

    localparam logic [17:0] K_SQ2_8 = 18'd185364;
    localparam logic [17:0] K_HEAD  = 18'd174993;
    localparam logic [29:0] K_GAIN  = 30'd652032874;
    localparam logic [19:0] ONE_E6  = 20'd1000000;

    localparam logic [31:0] C_ATAN [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic [2:0] {
        CFG_WHEEL_RADIUS    = 3'd0,
        CFG_CENTER_DISTANCE = 3'd1,
        CFG_OFFSET_X        = 3'd2,
        CFG_OFFSET_Y        = 3'd3,
        CFG_OFFSET_ANGLE    = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        STEP_IDLE,
        STEP_RK,
        STEP_VCX,
        STEP_VCY,
        STEP_WS,
        STEP_DIV_WZ,
        STEP_COR_OFF,
        STEP_VRX_A,
        STEP_VRX_B,
        STEP_VRY_A,
        STEP_VRY_B,
        STEP_LX_A,
        STEP_LX_B,
        STEP_LY_A,
        STEP_LY_B,
        STEP_VBX,
        STEP_VBY,
        STEP_DTK,
        STEP_HD,
        STEP_COR_HD,
        STEP_OX_A,
        STEP_OX_B,
        STEP_OY_A,
        STEP_OY_B,
        STEP_PX,
        STEP_DIV_PX,
        STEP_PY,
        STEP_DIV_PY,
        STEP_DONE
    } t_step;

    typedef struct packed {
        logic mul;
        logic div;
        logic cor;
    } t_unit_ctl;

endpackage

[design/ody_mul.sv]
// ----------------------------------------------------------------------------
// Bit-serial signed multiplier
// Shift-and-add over the bits of the second operand, one bit per cycle,
// with the sign bit subtracted on the last cycle.
// ----------------------------------------------------------------------------
module ody_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [ody_pkg::MUL_AW-1:0]   i_a,
    input  logic signed [ody_pkg::MUL_BW-1:0]   i_b,
    output logic                                o_done,
    output logic signed [ody_pkg::MUL_PW-1:0]   o_product
);

    localparam int AW    = ody_pkg::MUL_AW;
    localparam int BW    = ody_pkg::MUL_BW;
    localparam int CNT_W = $clog2(BW);

    logic signed [AW-1:0] r_a;
    logic signed [AW:0]   r_hi;
    logic [BW-1:0]        r_lo;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_run;
    logic                 r_done;

    logic                 w_last;
    logic signed [AW:0]   w_a_ext;
    logic signed [AW:0]   w_addend;
    logic signed [AW:0]   w_sum;

    assign w_last   = (r_cnt == CNT_W'(BW - 1));
    assign w_a_ext  = (AW + 1)'(r_a);
    assign w_addend = r_lo[0] ? (w_last ? -w_a_ext : w_a_ext) : '0;
    assign w_sum    = r_hi + w_addend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_run) begin
            r_hi <= w_sum >>> 1;
            r_lo <= {w_sum[0], r_lo[BW-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi[AW-1:0], r_lo};

endmodule

[design/ody_div.sv]
// ----------------------------------------------------------------------------
// Bit-serial rounding divider
// Restoring division, one quotient bit per cycle, rounding half away
// from zero by adding half the divisor to the magnitude first.
// ----------------------------------------------------------------------------
module ody_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [ody_pkg::DIV_NW-1:0]   i_num,
    input  logic [ody_pkg::DIV_DW-1:0]          i_den,
    output logic                                o_done,
    output logic signed [ody_pkg::DIV_NW-1:0]   o_quot
);

    localparam int NW    = ody_pkg::DIV_NW;
    localparam int DW    = ody_pkg::DIV_DW;
    localparam int CNT_W = $clog2(NW);

    logic [NW-1:0]    r_q;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;

    logic [NW-1:0]    w_mag;
    logic [NW-1:0]    w_start_q;
    logic [DW:0]      w_shift;
    logic             w_ge;
    logic [DW:0]      w_sub;
    logic             w_last;

    assign w_mag     = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
    assign w_start_q = w_mag + NW'(i_den >> 1);
    assign w_shift   = {r_rem, r_q[NW-1]};
    assign w_ge      = (w_shift >= {1'b0, r_den});
    assign w_sub     = w_shift - {1'b0, r_den};
    assign w_last    = (r_cnt == CNT_W'(NW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= w_start_q;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[NW-1];
        end else if (r_run) begin
            r_rem <= w_ge ? w_sub[DW-1:0] : w_shift[DW-1:0];
            r_q   <= {r_q[NW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -signed'(r_q) : signed'(r_q);

endmodule

[design/ody_cor.sv]
// ----------------------------------------------------------------------------
// Iterative CORDIC sine and cosine
// Rotation mode, one micro-rotation per cycle, on a 32-bit binary angle
// folded into the right half plane first.
// ----------------------------------------------------------------------------
module ody_cor #(
    parameter int STAGES = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [ody_pkg::COR_W-1:0]          i_angle,
    output logic                               o_done,
    output logic signed [ody_pkg::COR_W-1:0]   o_cos,
    output logic signed [ody_pkg::COR_W-1:0]   o_sin
);

    localparam int W     = ody_pkg::COR_W;
    localparam int CNT_W = $clog2(STAGES + 1);

    logic signed [W:0] r_x;
    logic signed [W:0] r_y;
    logic signed [W:0] r_z;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_run;
    logic              r_done;

    logic signed [W:0] w_z0;
    logic signed [W:0] w_zf;
    logic              w_fold;
    logic signed [W:0] w_dx;
    logic signed [W:0] w_dy;
    logic signed [W:0] w_atan;
    logic              w_last;
    logic signed [W:0] w_cos;
    logic signed [W:0] w_sin;

    assign w_z0 = (W + 1)'(signed'(i_angle));

    always_comb begin
        w_zf   = w_z0;
        w_fold = 1'b0;
        priority if (w_z0 > ((W + 1)'(1) <<< (W - 2))) begin
            w_zf   = w_z0 - ((W + 1)'(1) <<< (W - 1));
            w_fold = 1'b1;
        end else if (w_z0 < -((W + 1)'(1) <<< (W - 2))) begin
            w_zf   = w_z0 + ((W + 1)'(1) <<< (W - 1));
            w_fold = 1'b1;
        end
    end

    assign w_dx   = r_y >>> r_cnt;
    assign w_dy   = r_x >>> r_cnt;
    assign w_atan = (W + 1)'(ody_pkg::C_ATAN[5'(r_cnt)]);
    assign w_last = (r_cnt == CNT_W'(STAGES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= (W + 1)'(ody_pkg::K_GAIN);
            r_y   <= '0;
            r_z   <= w_zf;
            r_neg <= w_fold;
        end else if (r_run) begin
            if (!r_z[W]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
        end
    end

    assign w_cos  = r_neg ? -r_x : r_x;
    assign w_sin  = r_neg ? -r_y : r_y;
    assign o_done = r_done;
    assign o_cos  = w_cos[W-1:0];
    assign o_sin  = w_sin[W-1:0];

endmodule

[design/omni_drive_odometry_core.sv]
// ----------------------------------------------------------------------------
// Omni drive odometry core
// Four-wheel X-omni odometry: wheel speeds in, base twist and pose out.
// ----------------------------------------------------------------------------
// Each input transaction carries four wheel speeds and a step time and gives
// exactly one result transaction. A step shorter than MIN_STEP_US returns the
// last twist and the current pose with accepted low.
// An accepted step runs through a sequencer that drives one bit-serial
// multiplier (22 products), one bit-serial divider (3 quotients) and one
// iterative CORDIC (2 rotations). Most of the time goes to the multiplier.
// A new transaction is taken once the previous result sits in the output
// register.
// ----------------------------------------------------------------------------
module omni_drive_odometry_core #(
    parameter int MIN_STEP_US   = 100,
    parameter int CORDIC_STAGES = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [23:0] i_speed_front_left,
    input  logic signed [23:0] i_speed_rear_left,
    input  logic signed [23:0] i_speed_rear_right,
    input  logic signed [23:0] i_speed_front_right,
    input  logic [19:0]        i_step_time,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_accepted,
    output logic signed [23:0] o_base_vel_x,
    output logic signed [23:0] o_base_vel_y,
    output logic signed [23:0] o_yaw_rate,
    output logic signed [31:0] o_pose_x,
    output logic signed [31:0] o_pose_y,
    output logic [31:0]        o_pose_heading
);

    localparam int PW = ody_pkg::MUL_PW;

    ody_pkg::t_step       r_step;
    ody_pkg::t_step       n_step;
    logic                 r_busy;
    logic                 n_busy;
    ody_pkg::t_unit_ctl   w_start;

    logic [15:0]          r_wheel_radius;
    logic [15:0]          r_center_distance;
    logic signed [23:0]   r_offset_x;
    logic signed [23:0]   r_offset_y;
    logic [15:0]          r_offset_angle;

    logic signed [25:0]   r_sx;
    logic signed [25:0]   r_sy;
    logic signed [25:0]   r_sw;
    logic [19:0]          r_dt;
    logic                 r_ok;

    logic signed [34:0]   r_rk;
    logic signed [25:0]   r_vcx;
    logic signed [25:0]   r_vcy;
    logic signed [47:0]   r_num;
    logic signed [31:0]   r_ca;
    logic signed [31:0]   r_sa;
    logic signed [31:0]   r_ch;
    logic signed [31:0]   r_sh;
    logic signed [PW-1:0] r_acc;
    logic signed [27:0]   r_vrx;
    logic signed [27:0]   r_vry;
    logic signed [27:0]   r_lx;
    logic signed [27:0]   r_ly;
    logic [37:0]          r_dtk;
    logic signed [27:0]   r_ox;
    logic signed [27:0]   r_oy;

    logic signed [23:0]   r_vbx;
    logic signed [23:0]   r_vby;
    logic signed [23:0]   r_wz;
    logic [31:0]          r_heading;
    logic signed [31:0]   r_pos_x;
    logic signed [31:0]   r_pos_y;

    logic                 r_out_valid;
    logic                 r_o_accepted;
    logic signed [23:0]   r_o_vel_x;
    logic signed [23:0]   r_o_vel_y;
    logic signed [23:0]   r_o_yaw;
    logic signed [31:0]   r_o_pos_x;
    logic signed [31:0]   r_o_pos_y;
    logic [31:0]          r_o_heading;

    logic                 w_in_fire;
    logic                 w_ok;
    logic                 w_is_div;
    logic                 w_is_cor;
    logic                 w_unit_done;
    logic                 w_wb;

    logic signed [ody_pkg::MUL_AW-1:0] w_mul_a;
    logic signed [ody_pkg::MUL_BW-1:0] w_mul_b;
    logic signed [PW-1:0]              w_prod;
    logic                              w_mul_done;
    logic [ody_pkg::DIV_DW-1:0]        w_den;
    logic [15:0]                       w_dist;
    logic signed [47:0]                w_quot;
    logic                              w_div_done;
    logic [31:0]                       w_angle;
    logic signed [31:0]                w_cos;
    logic signed [31:0]                w_sin;
    logic                              w_cor_done;

    logic signed [PW-1:0] w_rnd36;
    logic signed [PW:0]   w_sum;
    logic signed [PW:0]   w_dif;
    logic signed [PW:0]   w_sum_r;
    logic signed [PW:0]   w_dif_r;
    logic signed [27:0]   w_r30s;
    logic signed [27:0]   w_r30d;
    logic signed [PW-1:0] w_r16_full;
    logic signed [39:0]   w_r16;
    logic signed [40:0]   w_vbx_pre;
    logic signed [40:0]   w_vby_pre;
    logic signed [PW-1:0] w_hd_full;
    logic [31:0]          w_hinc;
    logic signed [48:0]   w_px_sum;
    logic signed [48:0]   w_py_sum;

    function automatic logic signed [23:0] f_sat24(input logic signed [48:0] v);
        logic signed [23:0] res;
        if (v > 49'sd8388607) begin
            res = 24'sh7FFFFF;
        end else if (v < -49'sd8388608) begin
            res = 24'sh800000;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [48:0] v);
        logic signed [31:0] res;
        if (v > 49'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -49'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_step == ody_pkg::STEP_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_ok        = (32'(i_step_time) >= 32'(MIN_STEP_US));

    assign w_is_div = (r_step == ody_pkg::STEP_DIV_WZ) || (r_step == ody_pkg::STEP_DIV_PX)
                   || (r_step == ody_pkg::STEP_DIV_PY);
    assign w_is_cor = (r_step == ody_pkg::STEP_COR_OFF) || (r_step == ody_pkg::STEP_COR_HD);
    assign w_unit_done = w_is_div ? w_div_done : (w_is_cor ? w_cor_done : w_mul_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ody_pkg::STEP_IDLE;
            r_busy <= 1'b0;
        end else begin
            r_step <= n_step;
            r_busy <= n_busy;
        end
    end

    always_comb begin
        n_step  = r_step;
        n_busy  = r_busy;
        w_start = '0;
        w_wb    = 1'b0;
        unique case (r_step)
            ody_pkg::STEP_IDLE: begin
                if (w_in_fire) begin
                    n_step = w_ok ? ody_pkg::STEP_RK : ody_pkg::STEP_DONE;
                end
            end
            ody_pkg::STEP_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_step = ody_pkg::STEP_IDLE;
                end
            end
            default: begin
                if (!r_busy) begin
                    n_busy = 1'b1;
                    priority if (w_is_div) begin
                        w_start.div = 1'b1;
                    end else if (w_is_cor) begin
                        w_start.cor = 1'b1;
                    end else begin
                        w_start.mul = 1'b1;
                    end
                end else if (w_unit_done) begin
                    w_wb   = 1'b1;
                    n_busy = 1'b0;
                    n_step = ody_pkg::t_step'(5'(r_step) + 5'd1);
                end
            end
        endcase
    end

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_step)
            ody_pkg::STEP_RK: begin
                w_mul_a = ody_pkg::MUL_AW'(ody_pkg::K_SQ2_8);
                w_mul_b = ody_pkg::MUL_BW'(r_wheel_radius);
            end
            ody_pkg::STEP_VCX: begin
                w_mul_a = ody_pkg::MUL_AW'(r_rk);
                w_mul_b = ody_pkg::MUL_BW'(r_sx);
            end
            ody_pkg::STEP_VCY: begin
                w_mul_a = ody_pkg::MUL_AW'(r_rk);
                w_mul_b = ody_pkg::MUL_BW'(r_sy);
            end
            ody_pkg::STEP_WS: begin
                w_mul_a = ody_pkg::MUL_AW'(r_sw);
                w_mul_b = ody_pkg::MUL_BW'(r_wheel_radius);
            end
            ody_pkg::STEP_VRX_A: begin
                w_mul_a = ody_pkg::MUL_AW'(r_ca);
                w_mul_b = ody_pkg::MUL_BW'(r_vcx);
            end
            ody_pkg::STEP_VRX_B: begin
                w_mul_a = ody_pkg::MUL_AW'(r_sa);
                w_mul_b = ody_pkg::MUL_BW'(r_vcy);
            end
            ody_pkg::STEP_VRY_A: begin
                w_mul_a = ody_pkg::MUL_AW'(r_ca);
                w_mul_b = ody_pkg::MUL_BW'(r_vcy);
            end
            ody_pkg::STEP_VRY_B: begin
                w_mul_a = ody_pkg::MUL_AW'(r_sa);
                w_mul_b = ody_pkg::MUL_BW'(r_vcx);
            end
            ody_pkg::STEP_LX_A: begin
                w_mul_a = ody_pkg::MUL_AW'(r_ca);
                w_mul_b = ody_pkg::MUL_BW'(r_offset_x);
            end
            ody_pkg::STEP_LX_B: begin
                w_mul_a = ody_pkg::MUL_AW'(r_sa);
                w_mul_b = ody_pkg::MUL_BW'(r_offset_y);
            end
            ody_pkg::STEP_LY_A: begin
                w_mul_a = ody_pkg::MUL_AW'(r_sa);
                w_mul_b = ody_pkg::MUL_BW'(r_offset_x);
            end
            ody_pkg::STEP_LY_B: begin
                w_mul_a = ody_pkg::MUL_AW'(r_ca);
                w_mul_b = ody_pkg::MUL_BW'(r_offset_y);
            end
            ody_pkg::STEP_VBX: begin
                w_mul_a = ody_pkg::MUL_AW'(r_ly);
                w_mul_b = ody_pkg::MUL_BW'(r_wz);
            end
            ody_pkg::STEP_VBY: begin
                w_mul_a = ody_pkg::MUL_AW'(r_lx);
                w_mul_b = ody_pkg::MUL_BW'(r_wz);
            end
            ody_pkg::STEP_DTK: begin
                w_mul_a = ody_pkg::MUL_AW'(ody_pkg::K_HEAD);
                w_mul_b = ody_pkg::MUL_BW'(r_dt);
            end
            ody_pkg::STEP_HD: begin
                w_mul_a = ody_pkg::MUL_AW'(r_dtk);
                w_mul_b = ody_pkg::MUL_BW'(r_wz);
            end
            ody_pkg::STEP_OX_A, ody_pkg::STEP_OY_B: begin
                w_mul_a = ody_pkg::MUL_AW'(r_ch);
                w_mul_b = (r_step == ody_pkg::STEP_OX_A) ? ody_pkg::MUL_BW'(r_vbx)
                                                         : ody_pkg::MUL_BW'(r_vby);
            end
            ody_pkg::STEP_OX_B: begin
                w_mul_a = ody_pkg::MUL_AW'(r_sh);
                w_mul_b = ody_pkg::MUL_BW'(r_vby);
            end
            ody_pkg::STEP_OY_A: begin
                w_mul_a = ody_pkg::MUL_AW'(r_sh);
                w_mul_b = ody_pkg::MUL_BW'(r_vbx);
            end
            ody_pkg::STEP_PX: begin
                w_mul_a = ody_pkg::MUL_AW'(r_ox);
                w_mul_b = ody_pkg::MUL_BW'(r_dt);
            end
            ody_pkg::STEP_PY: begin
                w_mul_a = ody_pkg::MUL_AW'(r_oy);
                w_mul_b = ody_pkg::MUL_BW'(r_dt);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_dist  = (r_center_distance == 16'd0) ? 16'd1 : r_center_distance;
    assign w_den   = (r_step == ody_pkg::STEP_DIV_WZ) ? ody_pkg::DIV_DW'({w_dist, 2'b00})
                                                      : ody_pkg::ONE_E6;
    assign w_angle = (r_step == ody_pkg::STEP_COR_OFF) ? {r_offset_angle, 16'd0} : r_heading;

    ody_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start.mul),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_prod)
    );

    ody_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start.div),
        .i_num   (r_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    ody_cor #(
        .STAGES (CORDIC_STAGES)
    ) u_cor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start.cor),
        .i_angle (w_angle),
        .o_done  (w_cor_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    assign w_rnd36    = w_prod + (PW'(1) <<< 35);
    assign w_sum      = (PW + 1)'(r_acc) + (PW + 1)'(w_prod);
    assign w_dif      = (PW + 1)'(r_acc) - (PW + 1)'(w_prod);
    assign w_sum_r    = w_sum + ((PW + 1)'(1) <<< 29);
    assign w_dif_r    = w_dif + ((PW + 1)'(1) <<< 29);
    assign w_r30s     = w_sum_r[57:30];
    assign w_r30d     = w_dif_r[57:30];
    assign w_r16_full = w_prod + (PW'(1) <<< 15);
    assign w_r16      = w_r16_full[55:16];
    assign w_vbx_pre  = 41'(r_vrx) + 41'(w_r16);
    assign w_vby_pre  = 41'(r_vry) - 41'(w_r16);
    assign w_hd_full  = w_prod + (PW'(1) <<< 23);
    assign w_hinc     = w_hd_full[55:24];
    assign w_px_sum   = 49'(r_pos_x) + 49'(w_quot);
    assign w_py_sum   = 49'(r_pos_y) + 49'(w_quot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_radius    <= 16'd1;
            r_center_distance <= 16'd1;
            r_offset_x        <= '0;
            r_offset_y        <= '0;
            r_offset_angle    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ody_pkg::CFG_WHEEL_RADIUS:    r_wheel_radius    <= i_cfg_data[15:0];
                ody_pkg::CFG_CENTER_DISTANCE: r_center_distance <= i_cfg_data[15:0];
                ody_pkg::CFG_OFFSET_X:        r_offset_x        <= i_cfg_data;
                ody_pkg::CFG_OFFSET_Y:        r_offset_y        <= i_cfg_data;
                ody_pkg::CFG_OFFSET_ANGLE:    r_offset_angle    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_sx <= -26'(i_speed_front_left) + 26'(i_speed_front_right)
                  - 26'(i_speed_rear_left) + 26'(i_speed_rear_right);
            r_sy <= 26'(i_speed_front_left) + 26'(i_speed_front_right)
                  - 26'(i_speed_rear_left) - 26'(i_speed_rear_right);
            r_sw <= 26'(i_speed_front_left) + 26'(i_speed_front_right)
                  + 26'(i_speed_rear_left) + 26'(i_speed_rear_right);
            r_dt <= i_step_time;
            r_ok <= w_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wb) begin
            unique case (r_step)
                ody_pkg::STEP_RK:      r_rk  <= w_prod[34:0];
                ody_pkg::STEP_VCX:     r_vcx <= w_rnd36[61:36];
                ody_pkg::STEP_VCY:     r_vcy <= w_rnd36[61:36];
                ody_pkg::STEP_WS:      r_num <= w_prod[47:0];
                ody_pkg::STEP_COR_OFF: begin
                    r_ca <= w_cos;
                    r_sa <= w_sin;
                end
                ody_pkg::STEP_VRX_A:   r_acc <= w_prod;
                ody_pkg::STEP_VRX_B:   r_vrx <= w_r30s;
                ody_pkg::STEP_VRY_A:   r_acc <= w_prod;
                ody_pkg::STEP_VRY_B:   r_vry <= w_r30d;
                ody_pkg::STEP_LX_A:    r_acc <= w_prod;
                ody_pkg::STEP_LX_B:    r_lx  <= -w_r30s;
                ody_pkg::STEP_LY_A:    r_acc <= w_prod;
                ody_pkg::STEP_LY_B:    r_ly  <= w_r30d;
                ody_pkg::STEP_DTK:     r_dtk <= w_prod[37:0];
                ody_pkg::STEP_COR_HD: begin
                    r_ch <= w_cos;
                    r_sh <= w_sin;
                end
                ody_pkg::STEP_OX_A:    r_acc <= w_prod;
                ody_pkg::STEP_OX_B:    r_ox  <= w_r30d;
                ody_pkg::STEP_OY_A:    r_acc <= w_prod;
                ody_pkg::STEP_OY_B:    r_oy  <= w_r30s;
                ody_pkg::STEP_PX:      r_num <= w_prod[47:0];
                ody_pkg::STEP_PY:      r_num <= w_prod[47:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbx     <= '0;
            r_vby     <= '0;
            r_wz      <= '0;
            r_heading <= '0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
        end else if (w_wb) begin
            unique case (r_step)
                ody_pkg::STEP_DIV_WZ: r_wz      <= f_sat24(49'(w_quot));
                ody_pkg::STEP_VBX:    r_vbx     <= f_sat24(49'(w_vbx_pre));
                ody_pkg::STEP_VBY:    r_vby     <= f_sat24(49'(w_vby_pre));
                ody_pkg::STEP_HD:     r_heading <= r_heading + w_hinc;
                ody_pkg::STEP_DIV_PX: r_pos_x   <= f_sat32(w_px_sum);
                ody_pkg::STEP_DIV_PY: r_pos_y   <= f_sat32(w_py_sum);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_step == ody_pkg::STEP_DONE && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_step == ody_pkg::STEP_DONE && (!r_out_valid || i_out_ready)) begin
            r_o_accepted <= r_ok;
            r_o_vel_x    <= r_vbx;
            r_o_vel_y    <= r_vby;
            r_o_yaw      <= r_wz;
            r_o_pos_x    <= r_pos_x;
            r_o_pos_y    <= r_pos_y;
            r_o_heading  <= r_heading;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_o_accepted;
    assign o_base_vel_x   = r_o_vel_x;
    assign o_base_vel_y   = r_o_vel_y;
    assign o_yaw_rate     = r_o_yaw;
    assign o_pose_x       = r_o_pos_x;
    assign o_pose_y       = r_o_pos_y;
    assign o_pose_heading = r_o_heading;

    // Only one arithmetic unit is launched at a time.
    a_one_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_start.mul, w_start.div, w_start.cor}))
        else $error("more than one unit started");

    // A unit reports completion only while the sequencer waits on it.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mul_done || w_div_done || w_cor_done) |-> r_busy)
        else $error("unit completion without a pending operation");

    // A new result appears only after the final sequencer step.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_step == ody_pkg::STEP_DONE))
        else $error("result raised outside the final step");

    // The heading moves only on the heading integration step.
    a_heading_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_heading)) |-> $past(r_step == ody_pkg::STEP_HD))
        else $error("heading changed outside its integration step");

endmodule
